// ===== src/damped_jacobi_stencil_sweep_defines.svh =====
// Assertion macros shared by the stencil sweep RTL.
`ifndef DAMPED_JACOBI_STENCIL_SWEEP_DEFINES_SVH
`define DAMPED_JACOBI_STENCIL_SWEEP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DSJ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dsj_pkg.sv =====
package dsj_pkg;

  localparam int MAX_EDGE   = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 28;
  localparam int ADDR_W     = $clog2(MAX_EDGE);
  localparam int EDGE_W     = 11;
  localparam int GAIN_W     = 29;
  localparam int CFG_DATA_W = 29;
  localparam int CFG_IDX_W  = 2;
  localparam int IDX_W      = 10;
  localparam int WIN_CELLS  = 2;

  localparam logic [EDGE_W-1:0] EDGE_RESET     = EDGE_W'(514);
  localparam logic [GAIN_W-1:0] NBR_GAIN_RESET = GAIN_W'(65472062);
  localparam logic [GAIN_W-1:0] OLD_GAIN_RESET = GAIN_W'(6547206);
  localparam logic [EDGE_W-1:0] EDGE_MIN       = EDGE_W'(3);
  localparam logic [EDGE_W-1:0] EDGE_MAX       = EDGE_W'(MAX_EDGE);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EDGE_LENGTH   = 2'd0,
    CFG_NEIGHBOR_GAIN = 2'd1,
    CFG_OLD_GAIN      = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] estimate_value;
    logic signed [DATA_WIDTH-1:0] source_value;
    logic signed [DATA_WIDTH-1:0] previous_value;
    logic                         frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] relaxed_value;
    logic [IDX_W-1:0]             row_index;
    logic [IDX_W-1:0]             column_index;
    logic                         last_result;
  } out_item_t;

  // One column of the stencil window: rows r-2, r-1 and r.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] up;
    logic signed [DATA_WIDTH-1:0] mid;
    logic signed [DATA_WIDTH-1:0] down;
  } column_t;

endpackage

// ===== src/dsj_line_ram.sv =====
module dsj_line_ram (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [dsj_pkg::ADDR_W-1:0]       wr_addr_i,
  input  logic [dsj_pkg::DATA_WIDTH-1:0]   wr_data_i,
  input  logic                             rd_en_i,
  input  logic [dsj_pkg::ADDR_W-1:0]       rd_addr_a_i,
  input  logic [dsj_pkg::ADDR_W-1:0]       rd_addr_b_i,
  output logic [dsj_pkg::DATA_WIDTH-1:0]   rd_data_a_o,
  output logic [dsj_pkg::DATA_WIDTH-1:0]   rd_data_b_o
);
  import dsj_pkg::*;

  logic [DATA_WIDTH-1:0] mem [MAX_EDGE];
  logic [DATA_WIDTH-1:0] rd_a_q;
  logic [DATA_WIDTH-1:0] rd_b_q;

  // Read returns the contents from before a same-cycle write.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem[rd_addr_a_i];
      rd_b_q <= mem[rd_addr_b_i];
    end
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

// ===== src/dsj_window_cell.sv =====
module dsj_window_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  dsj_pkg::column_t col_i,
  output dsj_pkg::column_t col_o
);
  import dsj_pkg::*;

  column_t col_q;

  // Take the neighbor's column on every window shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ===== src/damped_jacobi_stencil_sweep.sv =====
// Channel   Direction  Handshake               Payload
// in        sink       in_valid_i / in_stall_o   dsj_pkg::in_item_t  (one grid point)
// out       source     out_valid_o / out_stall_i dsj_pkg::out_item_t (one interior update)
// cfg       sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// One grid point per cycle while the output does not stall; each point goes
// through line-buffer read, window shift, neighbor sum, gain multiply,
// accumulate and round/saturate; the output register holds the finished result.
// Reset is asynchronous and active low; line buffers are not cleared, so no
// clearing pass follows reset. in_stall_o rises only when every stage is
// occupied and the output register holds a result that is stalled.
`include "damped_jacobi_stencil_sweep_defines.svh"

module damped_jacobi_stencil_sweep (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  dsj_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output dsj_pkg::out_item_t               out_item_o,
  input  logic                             cfg_we_i,
  input  logic [dsj_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dsj_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import dsj_pkg::*;

  localparam int NSUM_W   = DATA_WIDTH + 2;
  localparam int BASE_W   = DATA_WIDTH + 1;
  localparam int PROD_N_W = NSUM_W + GAIN_W + 1;
  localparam int PROD_O_W = DATA_WIDTH + GAIN_W + 1;
  localparam int TOTAL_W  = PROD_N_W;
  localparam int Q_W      = TOTAL_W - FRAC_BITS - 1;
  localparam logic signed [TOTAL_W-1:0] ROUND_HALF = TOTAL_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [EDGE_W-1:0] edge_q;
  logic [GAIN_W-1:0] nbr_gain_q;
  logic [GAIN_W-1:0] old_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q     <= EDGE_RESET;
      nbr_gain_q <= NBR_GAIN_RESET;
      old_gain_q <= OLD_GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_EDGE_LENGTH:   edge_q     <= cfg_data_i[EDGE_W-1:0];
        CFG_NEIGHBOR_GAIN: nbr_gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_OLD_GAIN:      old_gain_q <= cfg_data_i[GAIN_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: each stage moves when the next one frees up. Points outside
  // the interior leave after the window stage and never reach the output.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic int2_q;
  logic rdy_o, rdy5, rdy4, rdy3, rdy2, rdy1;
  logic accept;

  assign rdy_o  = !vo_q || !out_stall_i;
  assign rdy5   = !v5_q || rdy_o;
  assign rdy4   = !v4_q || rdy5;
  assign rdy3   = !v3_q || rdy4;
  assign rdy2   = !v2_q || !int2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign accept = in_valid_i && rdy1;

  assign in_stall_o = !rdy1;

  // ---------------------------------------------------------------------------
  // Stage 0: raster position, line buffer access
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] row_q, col_q;
  logic [ADDR_W-1:0] row_d, col_d;
  logic [EDGE_W-1:0] edge_len;
  logic              col_wrap;
  logic [ADDR_W-1:0] cur_col;
  logic [EDGE_W-1:0] row_ext;
  logic [ADDR_W-1:0] cur_row;
  logic              interior;
  logic              last_pt;
  logic [EDGE_W-1:0] col_next;
  logic [EDGE_W-1:0] row_next;

  always_comb begin
    // Clamp the edge length to the supported range.
    edge_len = edge_q;
    if (edge_q < EDGE_MIN) edge_len = EDGE_MIN;
    if (edge_q > EDGE_MAX) edge_len = EDGE_MAX;

    // A counter left past the edge (edge changed) starts a new row or frame.
    col_wrap = {1'b0, col_q} >= edge_len;
    cur_col  = col_wrap ? '0 : col_q;
    row_ext  = col_wrap ? ({1'b0, row_q} + EDGE_W'(1)) : {1'b0, row_q};
    cur_row  = (row_ext >= edge_len) ? '0 : row_ext[ADDR_W-1:0];

    interior = (cur_row >= ADDR_W'(2)) && (cur_col != '0) &&
               (({1'b0, cur_col} + EDGE_W'(2)) <= edge_len);
    last_pt  = (({1'b0, cur_row} - EDGE_W'(1)) == (edge_len - EDGE_W'(2))) &&
               ({1'b0, cur_col} == (edge_len - EDGE_W'(2)));

    // Advance the raster position; frame end forces a new frame.
    col_next = {1'b0, cur_col} + EDGE_W'(1);
    row_next = {1'b0, cur_row} + EDGE_W'(1);
    if (in_item_i.frame_end) begin
      col_d = '0;
      row_d = '0;
    end else if (col_next >= edge_len) begin
      col_d = '0;
      row_d = (row_next >= edge_len) ? '0 : row_next[ADDR_W-1:0];
    end else begin
      col_d = col_next[ADDR_W-1:0];
      row_d = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Two line banks; even rows go to bank 0, odd rows to bank 1. The bank of
  // the current row still holds row r-2, the other one row r-1.
  logic [DATA_WIDTH-1:0] b0_a, b0_b, b1_a, b1_b;
  logic [ADDR_W-1:0]     right_col;

  assign right_col = cur_col + ADDR_W'(1);

  dsj_line_ram u_bank0 (
    .clk_i       (clk_i),
    .wr_en_i     (accept && !cur_row[0]),
    .wr_addr_i   (cur_col),
    .wr_data_i   (in_item_i.estimate_value),
    .rd_en_i     (accept),
    .rd_addr_a_i (cur_col),
    .rd_addr_b_i (right_col),
    .rd_data_a_o (b0_a),
    .rd_data_b_o (b0_b)
  );

  dsj_line_ram u_bank1 (
    .clk_i       (clk_i),
    .wr_en_i     (accept && cur_row[0]),
    .wr_addr_i   (cur_col),
    .wr_data_i   (in_item_i.estimate_value),
    .rd_en_i     (accept),
    .rd_addr_a_i (cur_col),
    .rd_addr_b_i (right_col),
    .rd_data_a_o (b1_a),
    .rd_data_b_o (b1_b)
  );

  // Source and previous value of the row above, one entry per column.
  logic [2*DATA_WIDTH-1:0] aux_mem [MAX_EDGE];
  logic [2*DATA_WIDTH-1:0] aux_rd_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      aux_rd_q         <= aux_mem[cur_col];
      aux_mem[cur_col] <= {in_item_i.previous_value, in_item_i.source_value};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: point metadata alongside the buffer read data
  // ---------------------------------------------------------------------------
  logic signed [DATA_WIDTH-1:0] est1_q;
  logic [IDX_W-1:0]             row1_q, col1_q;
  logic                         int1_q, last1_q, odd1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      est1_q  <= in_item_i.estimate_value;
      row1_q  <= cur_row - ADDR_W'(1);
      col1_q  <= cur_col;
      int1_q  <= interior;
      last1_q <= last_pt;
      odd1_q  <= cur_row[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: window shift through the cell chain
  // ---------------------------------------------------------------------------
  column_t                      win_col [WIN_CELLS+1];
  logic                         shift;
  logic signed [DATA_WIDTH-1:0] right1;

  assign shift          = v1_q && rdy2;
  assign win_col[0].up   = odd1_q ? b1_a : b0_a;
  assign win_col[0].mid  = odd1_q ? b0_a : b1_a;
  assign win_col[0].down = est1_q;
  assign right1          = odd1_q ? b0_b : b1_b;

  for (genvar k = 0; k < WIN_CELLS; k++) begin : g_win
    dsj_window_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .col_i   (win_col[k]),
      .col_o   (win_col[k+1])
    );
  end

  logic signed [DATA_WIDTH-1:0] right2_q, src2_q, old2_q;
  logic [IDX_W-1:0]             row2_q, col2_q;
  logic                         last2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q   <= 1'b0;
      int2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q   <= v1_q;
      int2_q <= v1_q && int1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      right2_q <= right1;
      src2_q   <= aux_rd_q[DATA_WIDTH-1:0];
      old2_q   <= aux_rd_q[2*DATA_WIDTH-1:DATA_WIDTH];
      row2_q   <= row1_q;
      col2_q   <= col1_q;
      last2_q  <= last1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: neighbor sum and center plus source
  // ---------------------------------------------------------------------------
  column_t                      center;
  logic signed [DATA_WIDTH-1:0] left;
  logic signed [NSUM_W-1:0]     nsum_d, nsum3_q;
  logic signed [BASE_W-1:0]     base_d, base3_q;
  logic signed [DATA_WIDTH-1:0] old3_q;
  logic [IDX_W-1:0]             row3_q, col3_q;
  logic                         last3_q;
  logic                         load3;

  assign center = win_col[1];
  assign left   = win_col[2].mid;
  assign load3  = v2_q && int2_q && rdy3;

  always_comb begin
    nsum_d = NSUM_W'(center.up) + NSUM_W'(center.down) + NSUM_W'(left) + NSUM_W'(right2_q);
    base_d = BASE_W'(src2_q) + BASE_W'(center.mid);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q && int2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load3) begin
      nsum3_q <= nsum_d;
      base3_q <= base_d;
      old3_q  <= old2_q;
      row3_q  <= row2_q;
      col3_q  <= col2_q;
      last3_q <= last2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: gain products
  // ---------------------------------------------------------------------------
  logic signed [GAIN_W:0]       nbr_gain_s, old_gain_s;
  logic signed [PROD_N_W-1:0]   prod_n_d, prod_n4_q;
  logic signed [PROD_O_W-1:0]   prod_o_d, prod_o4_q;
  logic signed [BASE_W-1:0]     base4_q;
  logic [IDX_W-1:0]             row4_q, col4_q;
  logic                         last4_q;

  assign nbr_gain_s = $signed({1'b0, nbr_gain_q});
  assign old_gain_s = $signed({1'b0, old_gain_q});
  assign prod_n_d   = nsum3_q * nbr_gain_s;
  assign prod_o_d   = old3_q * old_gain_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && rdy4) begin
      prod_n4_q <= prod_n_d;
      prod_o4_q <= prod_o_d;
      base4_q   <= base3_q;
      row4_q    <= row3_q;
      col4_q    <= col3_q;
      last4_q   <= last3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: accumulate the exact total
  // ---------------------------------------------------------------------------
  logic signed [TOTAL_W-1:0] total_d, total5_q;
  logic [IDX_W-1:0]          row5_q, col5_q;
  logic                      last5_q;

  assign total_d = $signed({base4_q, {FRAC_BITS{1'b0}}}) + prod_n4_q +
                   TOTAL_W'(prod_o4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (rdy5) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v4_q && rdy5) begin
      total5_q <= total_d;
      row5_q   <= row4_q;
      col5_q   <= col4_q;
      last5_q  <= last4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: halve with round half up, saturate
  // ---------------------------------------------------------------------------
  logic signed [TOTAL_W-1:0]    rounded;
  logic signed [Q_W-1:0]        quot;
  logic signed [DATA_WIDTH-1:0] relaxed_d;
  out_item_t                    out_q;

  always_comb begin
    rounded = total5_q + ROUND_HALF;
    quot    = rounded[TOTAL_W-1:FRAC_BITS+1];
    if (!quot[Q_W-1] && (|quot[Q_W-2:DATA_WIDTH-1])) begin
      relaxed_d = SAT_MAX;
    end else if (quot[Q_W-1] && !(&quot[Q_W-2:DATA_WIDTH-1])) begin
      relaxed_d = SAT_MIN;
    end else begin
      relaxed_d = quot[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdy_o) begin
      vo_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v5_q && rdy_o) begin
      out_q.relaxed_value <= relaxed_d;
      out_q.row_index     <= row5_q;
      out_q.column_index  <= col5_q;
      out_q.last_result   <= last5_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `DSJ_ASSERT_IMPLY(a_no_stall_when_out_free, clk_i, rst_ni, (!vo_q || !out_stall_i), !in_stall_o, "input stalled while output can drain")
  `DSJ_ASSERT_IMPLY(a_interior_only, clk_i, rst_ni, out_valid_o, (out_item_o.row_index != '0) && (out_item_o.column_index != '0), "result for a boundary point")
  `DSJ_ASSERT_IMPLY(a_last_on_diagonal, clk_i, rst_ni, (out_valid_o && out_item_o.last_result), (out_item_o.row_index == out_item_o.column_index), "last result off the final corner")
  `DSJ_ASSERT_NEXT(a_frame_end_restart, clk_i, rst_ni, (accept && in_item_i.frame_end), (row_q == '0) && (col_q == '0), "frame end did not restart the raster")

endmodule

// ===== dv/damped_jacobi_stencil_sweep_tb.sv =====
`timescale 1ns / 100ps

module damped_jacobi_stencil_sweep_tb;
  import dsj_pkg::*;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int RANDOM_POINTS = 1220;
  // Results trail their transfer through the pipeline; give the pipeline a margin.
  localparam int SETTLE_CYCLES = 16;

  localparam logic signed [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_TOP = '1;

  typedef enum int {
    IDLE_SENDER_LIGHT,
    IDLE_SENDER_HEAVY,
    IDLE_NONE
  } idle_profile_e;

  typedef enum int {
    FRAME_CLOSED,
    FRAME_WRAPPED,
    FRAME_CUT_SHORT,
    FRAME_OVERRUN
  } frame_shape_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;
  logic        cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  damped_jacobi_stencil_sweep dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Grid points waiting for the driver, and relaxed points the sweep should emit.
  in_item_t  point_q[$];
  out_item_t relaxed_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          in_taken;
  int          mismatches;
  int unsigned cycle_count;

  // Shadow of the configuration registers, kept in step with every write.
  logic [EDGE_W-1:0] edge_reg     = EDGE_RESET;
  logic [GAIN_W-1:0] nbr_gain_reg = NBR_GAIN_RESET;
  logic [GAIN_W-1:0] old_gain_reg = OLD_GAIN_RESET;

  // Shadow of the line buffers and the raster position. Row r lives in half r mod 2.
  logic signed [DATA_WIDTH-1:0] est_rows [2*MAX_EDGE];
  logic signed [DATA_WIDTH-1:0] src_row  [MAX_EDGE];
  logic signed [DATA_WIDTH-1:0] prv_row  [MAX_EDGE];
  logic signed [DATA_WIDTH-1:0] left_mid = '0;
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;

  // Clock: 4 ns period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic int unsigned clamp_edge(logic [EDGE_W-1:0] raw);
    if (raw < EDGE_MIN) return EDGE_MIN;
    if (raw > EDGE_MAX) return EDGE_MAX;
    return raw;
  endfunction

  // Advance the shadow sweep by one grid point; queue the relaxed point it completes.
  function automatic void relax_point(in_item_t pt);
    int unsigned len, r, c, cur, prv;
    logic signed [65:0] up_w, mid_w, dn_w, lf_w, rt_w, src_w, old_w, ng_w, og_w;
    logic signed [65:0] total, q, sat_hi, sat_lo;
    out_item_t res;
    len = clamp_edge(edge_reg);
    // A shrunken edge pushes a stale position onto the next row or a new frame.
    if (col_pos >= len) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= len) row_pos = 0;
    r   = row_pos;
    c   = col_pos;
    cur = (r % 2) * MAX_EDGE;
    prv = ((r + 1) % 2) * MAX_EDGE;
    mid_w = est_rows[prv + c];
    if (r >= 2 && c >= 1 && c + 2 <= len) begin
      // Center is row r-1; up is row r-2, down is the point arriving now.
      up_w   = est_rows[cur + c];
      dn_w   = pt.estimate_value;
      lf_w   = left_mid;
      rt_w   = est_rows[prv + c + 1];
      src_w  = src_row[c];
      old_w  = prv_row[c];
      ng_w   = nbr_gain_reg;
      og_w   = old_gain_reg;
      total  = ((src_w + mid_w) <<< FRAC_BITS) + (up_w + dn_w + lf_w + rt_w) * ng_w
             + old_w * og_w;
      // Halve with round half up, then clamp to the data range.
      q      = (total + (66'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
      sat_hi = (66'sd1 <<< (DATA_WIDTH - 1)) - 66'sd1;
      sat_lo = -sat_hi - 66'sd1;
      if (q > sat_hi) res.relaxed_value = MAX_V;
      else if (q < sat_lo) res.relaxed_value = MIN_V;
      else res.relaxed_value = q[DATA_WIDTH-1:0];
      res.row_index    = IDX_W'(r - 1);
      res.column_index = IDX_W'(c);
      res.last_result  = (r - 1 == len - 2) && (c == len - 2);
      relaxed_q.push_back(res);
    end
    left_mid = mid_w[DATA_WIDTH-1:0];
    est_rows[cur + c] = pt.estimate_value;
    src_row[c] = pt.source_value;
    prv_row[c] = pt.previous_value;
    if (pt.frame_end) begin
      row_pos = 0;
      col_pos = 0;
    end else begin
      col_pos = c + 1;
      if (col_pos >= len) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= len) row_pos = 0;
      end
    end
  endfunction

  // Check transfers out of the sweep, then fold accepted points into the shadow.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (relaxed_q.size() == 0) begin
          $error("unexpected result at row %0d column %0d",
                 out_item_o.row_index, out_item_o.column_index);
          mismatches++;
        end else begin
          out_item_t want;
          want = relaxed_q.pop_front();
          if (out_item_o.relaxed_value !== want.relaxed_value) begin
            $error("relaxed_value: expected %0d, got %0d",
                   want.relaxed_value, out_item_o.relaxed_value);
            mismatches++;
          end
          if (out_item_o.row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, out_item_o.row_index);
            mismatches++;
          end
          if (out_item_o.column_index !== want.column_index) begin
            $error("column_index: expected %0d, got %0d",
                   want.column_index, out_item_o.column_index);
            mismatches++;
          end
          if (out_item_o.last_result !== want.last_result) begin
            $error("last_result: expected %0d, got %0d",
                   want.last_result, out_item_o.last_result);
            mismatches++;
          end
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) relax_point(in_item_i);
    end
  end

  // Driver: present the next grid point once the previous one transferred; hold
  // a stalled point unchanged. Idle gaps are drawn independently of the stall.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item_i  <= point_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("damped_jacobi_stencil_sweep_tb: FAIL");
      $finish;
    end
  end

  task automatic set_idle(idle_profile_e prof);
    case (prof)
      IDLE_SENDER_LIGHT: begin
        send_idle_pct = 22;
        recv_idle_pct = 69;
      end
      IDLE_SENDER_HEAVY: begin
        send_idle_pct = 69;
        recv_idle_pct = 22;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Write one register; only called while the sweep is idle.
  task automatic cfg_write(cfg_index_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_EDGE_LENGTH:   edge_reg     = val[EDGE_W-1:0];
      CFG_NEIGHBOR_GAIN: nbr_gain_reg = val[GAIN_W-1:0];
      CFG_OLD_GAIN:      old_gain_reg = val[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every point transferred and every result arrived, then let the
  // pipeline settle so that points with no result have left it too.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (point_q.size() != 0 || in_valid_i || relaxed_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic push_point(logic signed [DATA_WIDTH-1:0] est, logic signed [DATA_WIDTH-1:0] src,
                            logic signed [DATA_WIDTH-1:0] prv, logic fend);
    in_item_t pt;
    pt.estimate_value = est;
    pt.source_value   = src;
    pt.previous_value = prv;
    pt.frame_end      = fend;
    point_q.push_back(pt);
  endtask

  // Mostly values near one, some full range, some pinned at the rails.
  function automatic logic signed [DATA_WIDTH-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return $urandom_range(1) ? MAX_V : MIN_V;
    if (pick < 40) return $urandom;
    return $urandom_range(32'h2000_0000) - 32'h1000_0000;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return GAIN_ONE;
      2:       return GAIN_TOP;
      3:       return $urandom & GAIN_TOP;
      4:       return $urandom_range(GAIN_ONE);
      default: return $urandom_range(32'h0400_0000);
    endcase
  endfunction

  // Queue n random points; raise frame_end on the last one if asked.
  task automatic push_run(int unsigned n, logic fend_last);
    for (int unsigned i = 0; i < n; i++)
      push_point(rand_sample(), rand_sample(), rand_sample(), fend_last && (i == n - 1));
  endtask

  // Queue one frame of edge len in the given shape; return the point count.
  task automatic push_frame(int unsigned len, frame_shape_e shape, output int unsigned n);
    case (shape)
      FRAME_CLOSED: begin
        n = len * len;
        push_run(n, 1'b1);
      end
      FRAME_WRAPPED: begin
        n = len * len;
        push_run(n, 1'b0);
      end
      FRAME_CUT_SHORT: begin
        n = $urandom_range(len * len - 1, 1);
        push_run(n, 1'b1);
      end
      default: begin
        n = len * len + $urandom_range(len * len - 1, 1);
        push_run(n, 1'b1);
      end
    endcase
  endtask

  initial begin
    int unsigned sent, phase, budget, taken, len_a, len_b;
    frame_shape_e shape;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    out_stall_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_EDGE_LENGTH;
    cfg_data_i    = '0;
    in_taken      = 1'b0;
    mismatches    = 0;
    cycle_count   = 0;
    rst_ni        = 1'b0;
    set_idle(IDLE_SENDER_LIGHT);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Edge below range clamps to 3; gains above one; both rails, saturating
    // high on a closed frame and low on a frame that wraps with no frame_end.
    cfg_write(CFG_EDGE_LENGTH, '0);
    cfg_write(CFG_NEIGHBOR_GAIN, GAIN_TOP);
    cfg_write(CFG_OLD_GAIN, GAIN_TOP);
    for (int i = 0; i < 9; i++) push_point(MAX_V, MAX_V, MAX_V, i == 8);
    for (int i = 0; i < 9; i++) push_point(MIN_V, MIN_V, MIN_V, 1'b0);
    wait_idle();

    // Shrink the edge mid-frame: the stale column starts the next row.
    cfg_write(CFG_EDGE_LENGTH, CFG_DATA_W'(4));
    cfg_write(CFG_NEIGHBOR_GAIN, '0);
    cfg_write(CFG_OLD_GAIN, GAIN_ONE);
    push_run(7, 1'b0);
    wait_idle();
    cfg_write(CFG_EDGE_LENGTH, CFG_DATA_W'(3));
    push_run(3, 1'b1);
    wait_idle();

    // Random phases, each under one pair of gains and left with the raster at the origin.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_POINTS) begin
      if (sent < RANDOM_POINTS / 3) set_idle(IDLE_SENDER_LIGHT);
      else if (sent < 2 * RANDOM_POINTS / 3) set_idle(IDLE_SENDER_HEAVY);
      else set_idle(IDLE_NONE);
      cfg_write(CFG_NEIGHBOR_GAIN, rand_gain());
      cfg_write(CFG_OLD_GAIN, rand_gain());
      if (phase == 3) begin
        // Edge above range clamps to the maximum; run three full rows, then
        // end the frame early.
        cfg_write(CFG_EDGE_LENGTH, CFG_DATA_W'($urandom_range(2047, 1025)));
        push_run(3 * MAX_EDGE, 1'b1);
      end else if ($urandom_range(3) == 0) begin
        // Stop part way, shrink the edge, and finish the frame under the new one.
        len_a = $urandom_range(10, 4);
        cfg_write(CFG_EDGE_LENGTH, CFG_DATA_W'(len_a));
        taken = $urandom_range(len_a * len_a - 1, 1);
        push_run(taken, 1'b0);
        sent += taken;
        wait_idle();
        len_b = $urandom_range(len_a - 1, 3);
        cfg_write(CFG_EDGE_LENGTH, CFG_DATA_W'(len_b));
        taken = $urandom_range(2 * len_b * len_b, 1);
        push_run(taken, 1'b1);
        sent += taken;
      end else begin
        case ($urandom_range(9))
          0:       cfg_write(CFG_EDGE_LENGTH, CFG_DATA_W'($urandom_range(2)));
          1, 2:    cfg_write(CFG_EDGE_LENGTH, CFG_DATA_W'($urandom_range(16, 9)));
          default: cfg_write(CFG_EDGE_LENGTH, CFG_DATA_W'($urandom_range(8, 3)));
        endcase
        budget = $urandom_range(90, 30);
        taken  = 0;
        while (taken < budget) begin
          int unsigned n;
          case ($urandom_range(9))
            0:       shape = FRAME_WRAPPED;
            1:       shape = FRAME_CUT_SHORT;
            2:       shape = FRAME_OVERRUN;
            default: shape = FRAME_CLOSED;
          endcase
          push_frame(clamp_edge(edge_reg), shape, n);
          taken += n;
        end
        sent += taken;
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("damped_jacobi_stencil_sweep_tb: PASS");
    end else begin
      $display("damped_jacobi_stencil_sweep_tb: FAIL");
    end
    $finish;
  end

endmodule
